/* rtl/multi_axis_pid_position_loop_defines.svh */
// ----------------------------------------------------------------------------
// Multi-axis PID position loop - assertion macros
// Shared concurrent-assertion shorthands, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_AXIS_PID_POSITION_LOOP_DEFINES_SVH
`define MULTI_AXIS_PID_POSITION_LOOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MAPID_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mapid: check failed");

// Consequent checked in the cycle after the antecedent.
`define MAPID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mapid: check failed");

`endif

/* rtl/mapid_pkg.sv */
// ----------------------------------------------------------------------------
// mapid_pkg
// Types and register codes shared by the PID position loop modules.
// ----------------------------------------------------------------------------
package mapid_pkg;

  // Register map, word index (byte address / 4)
  typedef enum logic [1:0] {
    REG_PROP_GAIN   = 2'd0,
    REG_INTEG_GAIN  = 2'd1,
    REG_DERIV_GAIN  = 2'd2,
    REG_SETTLE_THR  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] integ_gain;
    logic signed [15:0] deriv_gain;
    logic        [15:0] settle_threshold;
  } cfg_t;

  // Per-sample operands handed to the control law
  typedef struct packed {
    logic signed [16:0] err;
    logic signed [31:0] integ_prev;
    logic signed [16:0] last_err;
    logic               has_last;
  } law_in_t;

  typedef struct packed {
    logic signed [31:0] integ_new;
    logic signed [15:0] drive;
    logic               settled;
  } law_out_t;

endpackage

/* rtl/mapid_law.sv */
// ----------------------------------------------------------------------------
// mapid_law
// PID control law for one sample: saturating integral, three products,
// floor shift by 8, 16-bit saturation and settle deadband.
// ----------------------------------------------------------------------------
module mapid_law
  import mapid_pkg::*;
(
  input  cfg_t     cfg_i,
  input  law_in_t  law_i,
  output law_out_t law_o
);

  logic signed [32:0] sum_wide;
  logic signed [31:0] integ_sat;
  logic signed [17:0] delta;
  logic signed [32:0] p_prop;
  logic signed [47:0] p_integ;
  logic signed [33:0] p_deriv;
  logic signed [48:0] acc;
  logic signed [40:0] acc_shr;
  logic signed [15:0] drive_sat;
  logic        [16:0] err_mag;
  logic               settled;

  always_comb begin
    sum_wide = 33'(law_i.integ_prev) + 33'(law_i.err);
    if (sum_wide[32] != sum_wide[31]) begin
      integ_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      integ_sat = sum_wide[31:0];
    end

    delta = law_i.has_last ? (18'(law_i.err) - 18'(law_i.last_err)) : 18'sd0;

    p_prop  = 33'(cfg_i.prop_gain)  * 33'(law_i.err);
    p_integ = 48'(cfg_i.integ_gain) * 48'(integ_sat);
    p_deriv = 34'(cfg_i.deriv_gain) * 34'(delta);

    acc     = 49'(p_prop) + 49'(p_integ) + 49'(p_deriv);
    acc_shr = 41'(acc >>> 8);

    if (acc_shr > 41'sd32767) begin
      drive_sat = 16'sh7fff;
    end else if (acc_shr < -41'sd32768) begin
      drive_sat = 16'sh8000;
    end else begin
      drive_sat = acc_shr[15:0];
    end

    err_mag = law_i.err[16] ? 17'(-law_i.err) : 17'(law_i.err);
    settled = err_mag < {1'b0, cfg_i.settle_threshold};

    law_o.integ_new = integ_sat;
    law_o.drive     = settled ? 16'sd0 : drive_sat;
    law_o.settled   = settled;
  end

endmodule

/* rtl/multi_axis_pid_position_loop.sv */
// Each beat is registered in stage B, its result in stage C. Throughput:
// one sample per cycle unless the output stalls, any axis order, same axis
// back to back. The limit is the single compute stage (three products and
// the integral update); per-axis state is read at accept and forwarded from
// the write. Reset (rst_ni low, async): gains and threshold to 0, all axes
// have no history and a zero integral, both pipeline stages empty.
// ----------------------------------------------------------------------------
// multi_axis_pid_position_loop
// Per-axis PID position loop with settle deadband, one drive beat per sample.
// ----------------------------------------------------------------------------
module multi_axis_pid_position_loop
  import mapid_pkg::*;
#(
  parameter int NUM_AXES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] axis, [18:3] target_angle, [34:19] measured_angle, [39:35] zero
  input  logic [39:0] s_axis_tdata,
  // [0] start_move
  input  logic [0:0]  s_axis_tuser,

  // Drive stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] axis_out, [18:3] drive, [23:19] zero
  output logic [23:0] m_axis_tdata,
  // [0] settled
  output logic [0:0]  m_axis_tuser,

  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int          AW        = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam logic [31:0] NumAxesW  = 32'(NUM_AXES);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t     cfg_q;
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PROP_GAIN:  cfg_q.prop_gain        <= pwdata[15:0];
        REG_INTEG_GAIN: cfg_q.integ_gain       <= pwdata[15:0];
        REG_DERIV_GAIN: cfg_q.deriv_gain       <= pwdata[15:0];
        REG_SETTLE_THR: cfg_q.settle_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back zero-extended
  always_comb begin
    unique case (cfg_idx)
      REG_PROP_GAIN:  prdata = {16'b0, cfg_q.prop_gain};
      REG_INTEG_GAIN: prdata = {16'b0, cfg_q.integ_gain};
      REG_DERIV_GAIN: prdata = {16'b0, cfg_q.deriv_gain};
      REG_SETTLE_THR: prdata = {16'b0, cfg_q.settle_threshold};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: input register (stage B) feeds the result register (stage C).
  // Stage B moves whenever C is empty or C's beat is taken this cycle.
  // --------------------------------------------------------------------------
  logic b_vld_q;
  logic m_vld_q;
  logic s_accept;
  logic b_adv;

  assign b_adv         = b_vld_q && (!m_vld_q || m_axis_tready);
  assign s_axis_tready = !b_vld_q || !m_vld_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Incoming fields
  logic [2:0]    in_axis;
  logic [AW-1:0] in_idx;

  assign in_axis = s_axis_tdata[2:0];
  assign in_idx  = AW'(in_axis);

  // Stage B payload
  logic        [2:0]  b_axis_q;
  logic signed [15:0] b_tgt_q;
  logic signed [15:0] b_meas_q;
  logic               b_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (s_accept) begin
      b_vld_q <= 1'b1;
    end else if (b_adv) begin
      b_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      b_axis_q  <= in_axis;
      b_tgt_q   <= s_axis_tdata[18:3];
      b_meas_q  <= s_axis_tdata[34:19];
      b_start_q <= s_axis_tuser[0];
    end
  end

  // --------------------------------------------------------------------------
  // Per-axis state. Integral and last error live in a small memory read at
  // accept; a history bit per axis (reset clears) says whether the entry
  // holds anything. Without history the integral and last error read as 0.
  // --------------------------------------------------------------------------
  logic signed [31:0] integ_mem [NUM_AXES];
  logic signed [16:0] err_mem   [NUM_AXES];
  logic [NUM_AXES-1:0] hist_q;

  logic signed [31:0] rd_integ_q;
  logic signed [16:0] rd_err_q;
  logic               byp_q;
  logic signed [31:0] byp_integ_q;
  logic signed [16:0] byp_err_q;

  logic [AW-1:0] b_idx;
  logic          b_in_range;
  logic          wr_en;
  law_in_t       law_in;
  law_out_t      law_out;

  assign b_idx      = AW'(b_axis_q);
  assign b_in_range = 32'(b_axis_q) < NumAxesW;
  assign wr_en      = b_adv && b_in_range;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      integ_mem[b_idx] <= law_out.integ_new;
      err_mem[b_idx]   <= law_in.err;
    end
  end

  // Registered read; catch the write of the same axis landing on this edge
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      rd_integ_q  <= integ_mem[in_idx];
      rd_err_q    <= err_mem[in_idx];
      byp_q       <= wr_en && (b_idx == in_idx);
      byp_integ_q <= law_out.integ_new;
      byp_err_q   <= law_in.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (wr_en) begin
      hist_q[b_idx] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B operands; a new move drops the history before use
  // --------------------------------------------------------------------------
  logic hist_ok;

  assign hist_ok = b_in_range && hist_q[b_idx] && !b_start_q;

  always_comb begin
    law_in.err        = 17'(b_tgt_q) - 17'(b_meas_q);
    law_in.has_last   = hist_ok;
    law_in.integ_prev = '0;
    law_in.last_err   = '0;
    if (hist_ok) begin
      law_in.integ_prev = byp_q ? byp_integ_q : rd_integ_q;
      law_in.last_err   = byp_q ? byp_err_q   : rd_err_q;
    end
  end

  mapid_law u_law (
    .cfg_i (cfg_q),
    .law_i (law_in),
    .law_o (law_out)
  );

  // --------------------------------------------------------------------------
  // Result register; an axis beyond the configured count reports zero drive
  // --------------------------------------------------------------------------
  logic        [2:0]  m_axis_q;
  logic signed [15:0] m_drive_q;
  logic               m_settled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (b_adv) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      m_axis_q    <= b_axis_q;
      m_drive_q   <= b_in_range ? law_out.drive : 16'sd0;
      m_settled_q <= b_in_range && law_out.settled;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {5'b0, m_drive_q, m_axis_q};
  assign m_axis_tuser  = m_settled_q;

endmodule

/* rtl/mapid_chk.sv */
// ----------------------------------------------------------------------------
// mapid_chk
// Port-level checks for the PID position loop, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_axis_pid_position_loop_defines.svh"

module mapid_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // A settled beat carries zero drive
  `MAPID_ASSERT_SAME(a_settled_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[18:3] == 16'd0)

  // With the result register empty the block takes samples
  `MAPID_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

  // An accepted sample moves through stage B to the output if not back-pressured
  `MAPID_ASSERT_NEXT(a_two_cycle, (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready, m_axis_tvalid)

  // A stalled result beat stays offered
  `MAPID_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind multi_axis_pid_position_loop mapid_chk u_mapid_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* test/mapid_drive_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mapid_drive_checker
// Watches the sample, drive and register ports, predicts each drive beat
// and compares it field by field with what the loop sends.
// ----------------------------------------------------------------------------
module mapid_drive_checker
  import mapid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NUM_AXES = 8;

  typedef struct packed {
    logic [2:0]         axis;
    logic signed [15:0] drive;
    logic               settled;
  } drive_beat_t;

  logic signed [15:0] prop_gain;
  logic signed [15:0] integ_gain;
  logic signed [15:0] deriv_gain;
  logic        [15:0] settle_thr;

  logic signed [31:0] integ_acc [NUM_AXES];
  logic signed [16:0] prev_err  [NUM_AXES];
  logic               has_prev  [NUM_AXES];

  drive_beat_t drive_q[$];
  drive_beat_t want;
  drive_beat_t got;
  logic [15:0] reg_val;

  function automatic drive_beat_t pid_drive_law(input logic [2:0] ax,
                                                input logic signed [15:0] tgt,
                                                input logic signed [15:0] meas,
                                                input logic start);
    drive_beat_t beat;
    longint err;
    longint isum;
    longint delta;
    longint acc;
    beat.axis    = ax;
    beat.drive   = '0;
    beat.settled = 1'b0;
    if (int'(ax) >= NUM_AXES) return beat;
    if (start) begin
      integ_acc[ax] = '0;
      prev_err[ax]  = '0;
      has_prev[ax]  = 1'b0;
    end
    err  = longint'(tgt) - longint'(meas);
    isum = longint'(integ_acc[ax]) + err;
    if (isum > 64'sd2147483647) isum = 64'sd2147483647;
    if (isum < -64'sd2147483648) isum = -64'sd2147483648;
    integ_acc[ax] = 32'(isum);
    delta = has_prev[ax] ? err - longint'(prev_err[ax]) : 0;
    prev_err[ax] = 17'(err);
    has_prev[ax] = 1'b1;
    acc = longint'(prop_gain) * err + longint'(integ_gain) * isum
        + longint'(deriv_gain) * delta;
    acc = acc >>> 8;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    // inside the deadband: zero the drive, flag settled
    if ((err < 0 ? -err : err) < longint'(settle_thr)) begin
      acc = 0;
      beat.settled = 1'b1;
    end
    beat.drive = 16'(acc);
    return beat;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain    = '0;
      integ_gain   = '0;
      deriv_gain   = '0;
      settle_thr   = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        integ_acc[i] = '0;
        prev_err[i]  = '0;
        has_prev[i]  = 1'b0;
      end
      drive_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_e'(paddr[3:2]))
            REG_PROP_GAIN:  prop_gain  = pwdata[15:0];
            REG_INTEG_GAIN: integ_gain = pwdata[15:0];
            REG_DERIV_GAIN: deriv_gain = pwdata[15:0];
            REG_SETTLE_THR: settle_thr = pwdata[15:0];
            default: ;
          endcase
        end else begin
          case (reg_idx_e'(paddr[3:2]))
            REG_PROP_GAIN:  reg_val = prop_gain;
            REG_INTEG_GAIN: reg_val = integ_gain;
            REG_DERIV_GAIN: reg_val = deriv_gain;
            default:        reg_val = settle_thr;
          endcase
          if (prdata[15:0] !== reg_val) begin
            $error("prdata mismatch: expected %0h, got %0h", reg_val, prdata[15:0]);
            fail_count_o++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready)
        drive_q.push_back(pid_drive_law(s_axis_tdata[2:0], s_axis_tdata[18:3],
                                        s_axis_tdata[34:19], s_axis_tuser[0]));

      if (m_axis_tvalid && m_axis_tready) begin
        got.axis    = m_axis_tdata[2:0];
        got.drive   = m_axis_tdata[18:3];
        got.settled = m_axis_tuser[0];
        if (drive_q.size() == 0) begin
          $error("drive beat for axis %0d with no sample pending", got.axis);
          fail_count_o++;
        end else begin
          want = drive_q.pop_front();
          if (got.axis !== want.axis) begin
            $error("axis_out mismatch: expected %0d, got %0d", want.axis, got.axis);
            fail_count_o++;
          end
          if (got.drive !== want.drive) begin
            $error("drive mismatch: expected %0d, got %0d", want.drive, got.drive);
            fail_count_o++;
          end
          if (got.settled !== want.settled) begin
            $error("settled mismatch: expected %0d, got %0d", want.settled, got.settled);
            fail_count_o++;
          end
        end
      end
      pending_o = drive_q.size();
    end
  end

endmodule

/* test/tb_multi_axis_pid_position_loop.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_axis_pid_position_loop
// Drives samples and register writes into the PID position loop with random
// gaps and back-pressure; the checker beside the block predicts and compares
// every drive beat, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_multi_axis_pid_position_loop;
  import mapid_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [2:0] axis, [18:3] target_angle, [34:19] measured_angle, [39:35] zero
  logic [39:0] s_axis_tdata  = '0;
  // [0] start_move
  logic [0:0]  s_axis_tuser  = '0;

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [2:0] axis_out, [18:3] drive, [23:19] zero
  logic [23:0] m_axis_tdata;
  // [0] settled
  logic [0:0]  m_axis_tuser;

  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          drives_pending;

  // Idle knobs: sender gaps between samples, receiver stalls after each beat
  logic        tx_idle_en    = 1'b1;
  logic        rx_stall_en   = 1'b1;
  int          rx_hold       = 0;

  // Per-axis move state for the well-formed part of the random stimulus
  logic signed [15:0] move_tgt  [8];
  logic signed [15:0] move_pos  [8];
  int                 move_left [8];

  multi_axis_pid_position_loop dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  mapid_drive_checker u_drive_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (drives_pending)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: after each accepted drive beat, draw a stall and hold tready
  // low for that many cycles. Count at the rising edge, drive at the falling.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      rx_hold <= rx_stall_en ? int'($urandom_range(0, 14)) : 0;
    else if (rx_hold != 0)
      rx_hold <= rx_hold - 1;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && (rx_hold == 0);
  end

  // One register transfer: setup cycle, then access until pready.
  // Begin at the next falling edge: psel never drops and rises in one step.
  task automatic apb_xfer(input logic wr, input reg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop tvalid and hold until every predicted drive beat has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (drives_pending != 0) @(negedge clk_i);
  endtask

  // Reprogram the loop once it is idle, then read every register back.
  task automatic program_loop(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] kd, input logic [15:0] thr);
    wait_drained();
    apb_xfer(1'b1, REG_PROP_GAIN,  kp);
    apb_xfer(1'b1, REG_INTEG_GAIN, ki);
    apb_xfer(1'b1, REG_DERIV_GAIN, kd);
    apb_xfer(1'b1, REG_SETTLE_THR, thr);
    apb_xfer(1'b0, REG_PROP_GAIN,  '0);
    apb_xfer(1'b0, REG_INTEG_GAIN, '0);
    apb_xfer(1'b0, REG_DERIV_GAIN, '0);
    apb_xfer(1'b0, REG_SETTLE_THR, '0);
    @(negedge clk_i);
  endtask

  // Send one sample beat. Entered at a falling edge; leaves at the falling
  // edge after acceptance with tvalid still high, so a back-to-back beat
  // just overwrites the data.
  task automatic send_sample(input logic [2:0] ax, input logic signed [15:0] tgt,
                             input logic signed [15:0] meas, input logic start);
    int gap;
    gap = tx_idle_en ? int'($urandom_range(0, 14)) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {5'b00000, meas, tgt, ax};
    s_axis_tuser  <= start;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] modest_gain();
    return 16'($urandom_range(0, 2047) - 1024);
  endfunction

  // Random traffic: mostly moves (start, then samples closing on the target)
  // on random axes, with some fully random samples mixed in as noise.
  task automatic run_random(input int n_items);
    logic [2:0] ax;
    int         diff;
    int         p;
    for (int k = 0; k < n_items; k++) begin
      ax = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) begin
        send_sample(ax, 16'($urandom), 16'($urandom), 1'($urandom));
      end else if (move_left[ax] == 0) begin
        move_tgt[ax]  = 16'($urandom);
        move_pos[ax]  = 16'($urandom);
        move_left[ax] = $urandom_range(3, 24);
        send_sample(ax, move_tgt[ax], move_pos[ax], 1'b1);
      end else begin
        diff = int'(move_tgt[ax]) - int'(move_pos[ax]);
        p = int'(move_pos[ax]) + diff / int'($urandom_range(2, 6))
          + int'($urandom_range(0, 16)) - 8;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        move_pos[ax] = 16'(p);
        move_left[ax]--;
        send_sample(ax, move_tgt[ax], move_pos[ax], 1'b0);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) move_left[i] = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extreme gains, zero threshold: the drive is never forced to zero.
    // First beats on axes 0 and 3 come with no history since reset.
    program_loop(16'h7fff, 16'h8000, 16'h7fff, 16'h0000);
    send_sample(3'd0, 16'sh7fff, -16'sh8000, 1'b0);
    send_sample(3'd0, -16'sh8000, 16'sh7fff, 1'b0);
    send_sample(3'd3, 16'sd0, 16'sd0, 1'b0);
    send_sample(3'd0, 16'sd0, 16'sd0, 1'b1);
    send_sample(3'd1, 16'sh7fff, 16'sh7fff, 1'b1);
    send_sample(3'd2, -16'sh8000, -16'sh8000, 1'b0);
    send_sample(3'd7, 16'sh7fff, -16'sh8000, 1'b1);
    send_sample(3'd7, 16'sh7fff, -16'sh8000, 1'b0);
    send_sample(3'd4, 16'sd1, -16'sd1, 1'b0);
    send_sample(3'd5, -16'sd300, 16'sd200, 1'b0);
    send_sample(3'd6, 16'sd1234, 16'sd1000, 1'b1);

    // Opposite extremes with the widest deadband: every beat but the full-scale
    // error settles, while the integral and history keep moving underneath.
    program_loop(16'h8000, 16'h7fff, 16'h8000, 16'hffff);
    send_sample(3'd7, 16'sd500, -16'sd500, 1'b0);
    send_sample(3'd7, -16'sd500, 16'sd500, 1'b0);
    send_sample(3'd0, 16'sh7fff, -16'sh8000, 1'b0);

    // Deadband edges at threshold 100: 99 settles, 100 does not, both signs
    program_loop(16'h0100, 16'h0080, 16'h0040, 16'd100);
    send_sample(3'd2, 16'sd99, 16'sd0, 1'b1);
    send_sample(3'd2, 16'sd100, 16'sd0, 1'b0);
    send_sample(3'd2, -16'sd99, 16'sd0, 1'b0);
    send_sample(3'd2, -16'sd100, 16'sd0, 1'b0);
    send_sample(3'd1, 16'sd0, 16'sd0, 1'b0);

    // Integral buildup on one axis at full rate: push the drive into the
    // positive limit, across to the negative limit, and back again.
    program_loop(16'h0000, 16'h0001, 16'h0000, 16'h0000);
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    send_sample(3'd5, 16'sh7fff, -16'sh8000, 1'b1);
    for (int n = 0; n < 150; n++) send_sample(3'd5, 16'sh7fff, -16'sh8000, 1'b0);
    for (int n = 0; n < 300; n++) send_sample(3'd5, -16'sh8000, 16'sh7fff, 1'b0);
    for (int n = 0; n < 150; n++) send_sample(3'd5, 16'sh7fff, -16'sh8000, 1'b0);

    // Random phases, each with its own settings and idle pattern
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_loop(modest_gain(), modest_gain(), modest_gain(),
                        16'($urandom_range(0, 2000)));
        1: program_loop(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000);
        2: program_loop(modest_gain(), modest_gain(), modest_gain(),
                        16'($urandom_range(0, 4000)));
        3: program_loop(modest_gain(), 16'h0000, modest_gain(),
                        16'($urandom_range(0, 500)));
        4: program_loop(16'h7fff, 16'h7fff, 16'h7fff, 16'($urandom_range(0, 3000)));
        default: program_loop(16'h8000, 16'h8000, 16'h8000, 16'hffff);
      endcase
      tx_idle_en  = (ph != 2) && (ph != 4);
      rx_stall_en = (ph != 3) && (ph != 4);
      run_random(200);
    end

    // Let the last beats drain, then idle for stragglers before the verdict
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && drives_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest correct run
  initial begin
    #6000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
